>>> rtl/core/gnqp_pkg.sv
package gnqp_pkg;

  localparam int MAX_QUEENS_DEF = 64;
  localparam int BOARD_SIZE_RST = 8;

  localparam int CFG_W   = 7;
  localparam int FIELD_W = 6;
  localparam int PAIRS_W = 11;

endpackage

>>> rtl/core/gnqp_ram.sv
module gnqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/greedy_n_queens_placer_core.sv
// Sequence: clear every count-table entry, place row 0 at the clamped first column, then for each later
// row scan n columns (count-table reads through a shared add/compare unit) and update the tables.
// A new start is taken only after the last row is reported; busy stays high meanwhile.
// Each result word is strobed on out_valid for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low): idle, board_size = 8; the count tables clear on every start.
module greedy_n_queens_placer_core #(
  parameter int MAX_QUEENS = gnqp_pkg::MAX_QUEENS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [gnqp_pkg::FIELD_W-1:0] in_first_column,
  output logic                         out_valid,
  output logic [gnqp_pkg::FIELD_W-1:0] out_row_index,
  output logic [gnqp_pkg::FIELD_W-1:0] out_queen_column,
  output logic [gnqp_pkg::PAIRS_W-1:0] out_attack_pairs,
  output logic                         out_last_row,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gnqp_pkg::CFG_W-1:0]   cfg_board_size
);

  localparam int AW  = $clog2(MAX_QUEENS);
  localparam int AW2 = $clog2(2 * MAX_QUEENS);
  localparam int NW  = $clog2(MAX_QUEENS + 1);
  localparam int CW  = $clog2(MAX_QUEENS);
  localparam int SW  = CW + 2;
  localparam int FW  = gnqp_pkg::FIELD_W;
  localparam int PW  = gnqp_pkg::PAIRS_W;
  localparam int GW  = gnqp_pkg::CFG_W;

  typedef enum logic [2:0] {ST_IDLE, ST_CLEAR, ST_FIRST, ST_SCAN, ST_UPDATE} state_t;

  state_t        state_r, state_nxt;
  logic [GW-1:0] cfg_size_r, cfg_size_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [AW-1:0] start_col_r, start_col_nxt;
  logic [AW2-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] row_r, row_nxt;
  logic          iss_on_r, iss_on_nxt;
  logic [AW-1:0] iss_col_r, iss_col_nxt;
  logic          p_v_r, p_v_nxt;
  logic [AW-1:0] p_col_r, p_col_nxt;
  logic [SW-1:0] best_hits_r, best_hits_nxt;
  logic [AW-1:0] best_col_r, best_col_nxt;
  logic [CW-1:0] best_c_r, best_c_nxt;
  logic [CW-1:0] best_d1_r, best_d1_nxt;
  logic [CW-1:0] best_d2_r, best_d2_nxt;
  logic [PW-1:0] pairs_r, pairs_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [FW-1:0] out_row_r, out_row_nxt;
  logic [FW-1:0] out_col_r, out_col_nxt;
  logic [PW-1:0] out_pairs_r, out_pairs_nxt;
  logic          out_last_r, out_last_nxt;

  logic [NW-1:0] size_eff;
  logic [NW-1:0] size_m1;
  logic [AW-1:0] start_clamp;
  logic [SW-1:0] hits;
  logic [PW-1:0] pairs_sum;

  logic           we;
  logic [AW-1:0]  c_waddr;
  logic [AW2-1:0] d1_waddr, d2_waddr;
  logic [CW-1:0]  c_wdata, d1_wdata, d2_wdata;
  logic [AW-1:0]  c_raddr;
  logic [AW2-1:0] d1_raddr, d2_raddr;
  logic [CW-1:0]  c_rdata, d1_rdata, d2_rdata;

  gnqp_ram #(.WIDTH(CW), .DEPTH(MAX_QUEENS)) u_col_ram (
    .clk(clk), .we(we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  gnqp_ram #(.WIDTH(CW), .DEPTH(2 * MAX_QUEENS)) u_diag_ram (
    .clk(clk), .we(we), .waddr(d1_waddr), .wdata(d1_wdata),
    .raddr(d1_raddr), .rdata(d1_rdata)
  );

  gnqp_ram #(.WIDTH(CW), .DEPTH(2 * MAX_QUEENS)) u_anti_ram (
    .clk(clk), .we(we), .waddr(d2_waddr), .wdata(d2_wdata),
    .raddr(d2_raddr), .rdata(d2_rdata)
  );

  always_comb begin
    if (cfg_size_r == '0) begin
      size_eff = NW'(1);
    end else if (cfg_size_r > GW'(MAX_QUEENS)) begin
      size_eff = NW'(MAX_QUEENS);
    end else begin
      size_eff = NW'(cfg_size_r);
    end
    size_m1 = size_eff - NW'(1);
    if (GW'(in_first_column) > GW'(size_m1)) begin
      start_clamp = AW'(size_m1);
    end else begin
      start_clamp = AW'(in_first_column);
    end
  end

  assign c_raddr  = iss_col_r;
  assign d1_raddr = AW2'(iss_col_r) + AW2'(MAX_QUEENS - 1) - AW2'(row_r);
  assign d2_raddr = AW2'(iss_col_r) + AW2'(row_r);

  assign hits      = SW'(c_rdata) + SW'(d1_rdata) + SW'(d2_rdata);
  assign pairs_sum = pairs_r + PW'(best_hits_r);

  always_comb begin
    we       = 1'b0;
    c_waddr  = best_col_r;
    d1_waddr = AW2'(best_col_r) + AW2'(MAX_QUEENS - 1) - AW2'(row_r);
    d2_waddr = AW2'(best_col_r) + AW2'(row_r);
    c_wdata  = best_c_r + CW'(1);
    d1_wdata = best_d1_r + CW'(1);
    d2_wdata = best_d2_r + CW'(1);
    case (state_r)
      ST_CLEAR: begin
        we       = 1'b1;
        c_waddr  = clr_addr_r[AW-1:0];
        d1_waddr = clr_addr_r;
        d2_waddr = clr_addr_r;
        c_wdata  = '0;
        d1_wdata = '0;
        d2_wdata = '0;
      end
      ST_FIRST: begin
        we       = 1'b1;
        c_waddr  = start_col_r;
        d1_waddr = AW2'(start_col_r) + AW2'(MAX_QUEENS - 1);
        d2_waddr = AW2'(start_col_r);
        c_wdata  = CW'(1);
        d1_wdata = CW'(1);
        d2_wdata = CW'(1);
      end
      ST_UPDATE: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cfg_size_nxt  = cfg_size_r;
    n_nxt         = n_r;
    start_col_nxt = start_col_r;
    clr_addr_nxt  = clr_addr_r;
    row_nxt       = row_r;
    iss_on_nxt    = 1'b0;
    iss_col_nxt   = iss_col_r;
    p_v_nxt       = 1'b0;
    p_col_nxt     = p_col_r;
    best_hits_nxt = best_hits_r;
    best_col_nxt  = best_col_r;
    best_c_nxt    = best_c_r;
    best_d1_nxt   = best_d1_r;
    best_d2_nxt   = best_d2_r;
    pairs_nxt     = pairs_r;
    out_valid_nxt = 1'b0;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_pairs_nxt = out_pairs_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid) begin
      cfg_size_nxt = cfg_board_size;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt         = size_eff;
          start_col_nxt = start_clamp;
          clr_addr_nxt  = '0;
          state_nxt     = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW2'(1);
        if (clr_addr_r == AW2'(2 * MAX_QUEENS - 1)) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        pairs_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_row_nxt   = '0;
        out_col_nxt   = FW'(start_col_r);
        out_pairs_nxt = '0;
        out_last_nxt  = (n_r == NW'(1));
        if (n_r == NW'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt       = AW'(1);
          iss_on_nxt    = 1'b1;
          iss_col_nxt   = '0;
          best_hits_nxt = '1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iss_on_r) begin
          p_v_nxt   = 1'b1;
          p_col_nxt = iss_col_r;
          if (NW'(iss_col_r) != n_r - NW'(1)) begin
            iss_on_nxt  = 1'b1;
            iss_col_nxt = iss_col_r + AW'(1);
          end
        end
        if (p_v_r) begin
          if (hits < best_hits_r) begin
            best_hits_nxt = hits;
            best_col_nxt  = p_col_r;
            best_c_nxt    = c_rdata;
            best_d1_nxt   = d1_rdata;
            best_d2_nxt   = d2_rdata;
          end
          if (NW'(p_col_r) == n_r - NW'(1)) begin
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        pairs_nxt     = pairs_sum;
        out_valid_nxt = 1'b1;
        out_row_nxt   = FW'(row_r);
        out_col_nxt   = FW'(best_col_r);
        out_pairs_nxt = pairs_sum;
        out_last_nxt  = (NW'(row_r) == n_r - NW'(1));
        if (NW'(row_r) == n_r - NW'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt       = row_r + AW'(1);
          iss_on_nxt    = 1'b1;
          iss_col_nxt   = '0;
          best_hits_nxt = '1;
          state_nxt     = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_size_r  <= GW'(gnqp_pkg::BOARD_SIZE_RST);
      iss_on_r    <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_size_r  <= cfg_size_nxt;
      iss_on_r    <= iss_on_nxt;
      p_v_r       <= p_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    start_col_r <= start_col_nxt;
    clr_addr_r  <= clr_addr_nxt;
    row_r       <= row_nxt;
    iss_col_r   <= iss_col_nxt;
    p_col_r     <= p_col_nxt;
    best_hits_r <= best_hits_nxt;
    best_col_r  <= best_col_nxt;
    best_c_r    <= best_c_nxt;
    best_d1_r   <= best_d1_nxt;
    best_d2_r   <= best_d2_nxt;
    pairs_r     <= pairs_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_pairs_r <= out_pairs_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_r;
  assign out_queen_column = out_col_r;
  assign out_attack_pairs = out_pairs_r;
  assign out_last_row     = out_last_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_row0_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_index == '0 |-> out_attack_pairs == '0)
    else $error("row zero reported nonzero pairs");

  a_pipe_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> state_r == ST_SCAN)
    else $error("compare stage valid outside scan");

  a_iss_range: assert property (@(posedge clk) disable iff (!rst_n)
    iss_on_r |-> NW'(iss_col_r) < n_r)
    else $error("column issue beyond board");

endmodule
